### rtl/core/spq_pkg.sv
// Sorted priority queue package: depth, widths, opcodes, status codes,
// beat structs and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package spq_pkg;

   localparam int DEPTH = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = 6;
   localparam int VAL_W = 32;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_DUMP   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]              func;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] data;
      logic [OCC_W-1:0]        occupancy;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic load_req;    // capture the request beat
      logic apply;       // run insert/delete and post the single result
      logic dump_start;  // rewind the dump pointer
      logic dump_emit;   // post the entry under the dump pointer
   } cmd_type;

   typedef struct packed {
      logic dump_op;     // held request is a dump
      logic empty;       // no entries stored
      logic out_free;    // output register can take a beat this cycle
      logic dump_last;   // dump pointer is at the last stored entry
   } stat_type;

endpackage

`default_nettype wire

### rtl/core/spq_ctrl.sv
// Sorted priority queue controller: sequences request capture, update and dump.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output cmd_type       cmd,
   input  wire stat_type stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_OP,
      S_DUMP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_OP;
            end
         end
         S_OP: begin
            if (stat.dump_op && !stat.empty) begin
               cmd.dump_start = 1'b1;
               state_in       = S_DUMP;
            end else if (stat.out_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_DUMP: begin
            if (stat.out_free) begin
               cmd.dump_emit = 1'b1;
               if (stat.dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/spq_dp.sv
// Sorted priority queue datapath: row of compare-and-shift cells, count,
// dump pointer and the output register. Depends on spq_pkg.
`default_nettype none

module spq_dp
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire cmd_type cmd,
   output stat_type     stat
);

   req_type                 req_ff;
   logic signed [VAL_W-1:0] entries_ff [DEPTH];
   logic signed [VAL_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [IDX_W-1:0]        idx_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_valid_ff;

   logic [DEPTH-1:0] ge;      // value >= entry, or cell beyond count
   logic [DEPTH-1:0] le;      // stored entry <= value
   logic [DEPTH-1:0] eq;      // stored entry == value
   logic             found;
   logic             full;
   logic             is_insert;
   logic             is_delete;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign found     = |eq;
   assign is_insert = (req_ff.func == FUNC_INSERT);
   assign is_delete = (req_ff.func == FUNC_DELETE);

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic cell_valid;
      assign cell_valid = (CNT_W'(g) < count_ff);
      assign ge[g] = !cell_valid || (entries_ff[g] <= req_ff.value);
      assign le[g] = cell_valid && (entries_ff[g] <= req_ff.value);
      assign eq[g] = cell_valid && (entries_ff[g] == req_ff.value);

      // Insert: take the value at the first cell where it fits, take the
      // left neighbor behind it. Delete: pull in the right neighbor from the
      // first match onward.
      if (g == 0) begin : g_first
         always_comb begin
            entries_in[g] = entries_ff[g];
            if (is_insert && !full && ge[g]) begin
               entries_in[g] = req_ff.value;
            end else if (is_delete && found && le[g]) begin
               entries_in[g] = entries_ff[g+1];
            end
         end
      end else if (g == DEPTH - 1) begin : g_end
         always_comb begin
            entries_in[g] = entries_ff[g];
            if (is_insert && !full && ge[g-1]) begin
               entries_in[g] = entries_ff[g-1];
            end else if (is_insert && !full && ge[g]) begin
               entries_in[g] = req_ff.value;
            end
         end
      end else begin : g_mid
         always_comb begin
            entries_in[g] = entries_ff[g];
            if (is_insert && !full && ge[g-1]) begin
               entries_in[g] = entries_ff[g-1];
            end else if (is_insert && !full && ge[g]) begin
               entries_in[g] = req_ff.value;
            end else if (is_delete && found && le[g]) begin
               entries_in[g] = entries_ff[g+1];
            end
         end
      end
   end

   // Single result of insert, delete or empty dump.
   always_comb begin
      count_in       = count_ff;
      rsp_in.status  = ST_OK;
      rsp_in.data    = req_ff.value;
      rsp_in.last    = 1'b1;
      if (req_ff.func[1]) begin
         rsp_in.status = ST_EMPTY;
         rsp_in.data   = '0;
      end else if (is_insert) begin
         if (full) begin
            rsp_in.status = ST_OVERFLOW;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (count_ff == '0) begin
         rsp_in.status = ST_EMPTY;
      end else if (!found) begin
         rsp_in.status = ST_NOT_FOUND;
      end else begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.apply && !req_ff.func[1]) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
      end else if (cmd.dump_emit) begin
         rsp_ff.status    <= ST_OK;
         rsp_ff.data      <= entries_ff[idx_ff];
         rsp_ff.occupancy <= OCC_W'(count_ff);
         rsp_ff.last      <= stat.dump_last;
      end
      if (cmd.dump_start) begin
         idx_ff <= '0;
      end else if (cmd.dump_emit) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.apply) begin
            count_ff <= count_in;
         end
         if (cmd.apply || cmd.dump_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.dump_op   = req_ff.func[1];
   assign stat.empty     = (count_ff == '0);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.dump_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.apply && cmd.dump_emit))
      else $error("output register loaded twice in one cycle");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && is_insert && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the queue by one");

   a_post_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.apply || cmd.dump_emit |=> rsp_valid_ff)
      else $error("posted result not marked valid");
`endif

endmodule

`default_nettype wire

### rtl/core/sorted_priority_queue_top.sv
// Sorted priority queue top: valid/ready request and response channels around
// the spq_ctrl controller and spq_dp datapath. Depends on spq_pkg.
// Order: the request beat is registered in the held request, then the result
// beat in the output register (one compare-and-shift update across all cells);
// a non-empty dump first rewinds its pointer, then posts from the first entry.
// Flow: a request is taken only after the last posted its final beat; a dump
// posts one beat per stored entry through the single output register. Each
// cycle that a waiting beat is not taken holds the update or the dump pointer.
// Reset: synchronous, active high; clears count and handshake state, entries
// are left as they are and never read beyond count.
`default_nettype none

module sorted_priority_queue_top
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // Commands flow from the controller into the datapath; status flows back.
   cmd_type  cmd;
   stat_type stat;

   // Controller: take one request beat, then either apply it once the output
   // register is free or step the dump pointer one beat per free output slot.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath: every cell compares against the held value in parallel and
   // shifts left or right in the same update; the output register holds a beat
   // until the consumer takes it.
   spq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench for sorted_priority_queue_top: random and directed insert, delete and dump
// traffic, checked beat by beat against a sorted-array predictor. Depends on spq_pkg.
`timescale 1ns / 1ps

module tb;
   import spq_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_OPS     = 500;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 16;
   // Worst case is far below this, with up to 32 beats per op and receiver stalls.
   localparam int TIMEOUT_NS     = 8_000_000;

   // func = 3 is not a named opcode; the block decodes it as a dump.
   localparam logic [1:0] FUNC_DUMP_ALT = 2'd3;

   typedef struct {
      req_type req;
      bit      drain;     // hold the sender until every expected beat has arrived
      bit      stall_rx;  // start the long receiver hold-off when this op is offered
   } pending_op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pending_op_type          pending_ops[$];
   rsp_type                 expected_beats[$];
   logic signed [VAL_W-1:0] gen_vals[$];     // contents as seen by the stimulus builder

   // Predictor state: sorted values, largest first, and how many are held.
   logic signed [VAL_W-1:0] queue_vals[DEPTH];
   int                      queue_count = 0;

   int total_ops = 0;
   int accepted_ops = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int burst_left = 1;
   int gap_left = 0;
   int rx_cycle = 0;
   int fail_count = 0;

   sorted_priority_queue_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one accepted op to the predictor and queue the beats it must produce.
   function automatic void predict_queue_op(req_type op);
      rsp_type beat;
      int      slot;
      beat.status = ST_OK;
      beat.data   = op.value;
      beat.last   = 1'b1;
      if (op.func[1]) begin
         // Dump: only the high bit of func is decoded, so 3 lands here too.
         if (queue_count == 0) begin
            beat.status    = ST_EMPTY;
            beat.data      = '0;
            beat.occupancy = '0;
            expected_beats.push_back(beat);
         end else begin
            for (int i = 0; i < queue_count; i++) begin
               beat.data      = queue_vals[i];
               beat.occupancy = OCC_W'(queue_count);
               beat.last      = (i == queue_count - 1);
               expected_beats.push_back(beat);
            end
         end
         return;
      end
      if (op.func == FUNC_INSERT) begin
         if (queue_count >= DEPTH) begin
            beat.status = ST_OVERFLOW;
         end else begin
            // Land in front of the first entry that is <= the new value,
            // so a duplicate goes ahead of its equals.
            slot = queue_count;
            for (int i = queue_count - 1; i >= 0; i--)
               if ($signed(op.value) >= queue_vals[i]) slot = i;
            for (int i = queue_count; i > slot; i--)
               queue_vals[i] = queue_vals[i - 1];
            queue_vals[slot] = op.value;
            queue_count++;
         end
      end else begin
         if (queue_count == 0) begin
            beat.status = ST_EMPTY;
         end else begin
            slot = -1;
            for (int i = queue_count - 1; i >= 0; i--)
               if (queue_vals[i] == op.value) slot = i;
            if (slot < 0) begin
               beat.status = ST_NOT_FOUND;
            end else begin
               // Close the gap left by the first match.
               for (int i = slot; i < queue_count - 1; i++)
                  queue_vals[i] = queue_vals[i + 1];
               queue_count--;
            end
         end
      end
      beat.occupancy = OCC_W'(queue_count);
      expected_beats.push_back(beat);
   endfunction

   // Compare one accepted result beat with the oldest expectation.
   function automatic void check_rsp(rsp_type got);
      rsp_type want;
      if (expected_beats.size() == 0) begin
         $error("unexpected result beat: status %0d data %0d occupancy %0d last %0d",
                got.status, $signed(got.data), got.occupancy, got.last);
         fail_count++;
         return;
      end
      want = expected_beats.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         fail_count++;
      end
      if (got.data !== want.data) begin
         $error("data: expected %0d, got %0d", $signed(want.data), $signed(got.data));
         fail_count++;
      end
      if (got.occupancy !== want.occupancy) begin
         $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         fail_count++;
      end
   endfunction

   // Queue one op and track what the queue will hold once it has run.
   task automatic push_op(input logic [1:0] f, input logic signed [VAL_W-1:0] v,
                          input bit stall = 1'b0);
      pending_op_type op;
      op.req.func  = f;
      op.req.value = v;
      op.drain     = 1'b0;
      op.stall_rx  = stall;
      pending_ops.push_back(op);
      total_ops++;
      if (f == FUNC_INSERT) begin
         if (gen_vals.size() < DEPTH) gen_vals.push_back(v);
      end else if (f == FUNC_DELETE) begin
         for (int i = 0; i < gen_vals.size(); i++)
            if (gen_vals[i] == v) begin
               gen_vals.delete(i);
               break;
            end
      end
   endtask

   task automatic push_drain();
      pending_op_type op;
      op.req      = '0;
      op.drain    = 1'b1;
      op.stall_rx = 1'b0;
      pending_ops.push_back(op);
   endtask

   // Mix full-range values with a narrow band and the extremes so that
   // duplicates and delete hits are common.
   function automatic logic signed [VAL_W-1:0] pick_value();
      int k;
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: begin
            k = $urandom_range(0, 8);
            return k - 4;
         end
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return '0;
               default: return -1;
            endcase
         end
         default: begin
            if (gen_vals.size() == 0) return $urandom;
            return gen_vals[$urandom_range(0, gen_vals.size() - 1)];
         end
      endcase
   endfunction

   // Sender: offer pending ops in bursts, hold valid and payload until taken.
   always @(posedge clock) begin : drive_req
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer      = 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_queue_op(req_data);
            accepted_ops++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (pending_ops.size() != 0 && pending_ops[0].drain) begin
               // Pause here until the block has delivered everything.
               if (expected_beats.size() == 0) void'(pending_ops.pop_front());
            end else if (gap_left != 0) begin
               gap_left--;
            end else if (pending_ops.size() != 0) begin
               req_data <= pending_ops[0].req;
               if (pending_ops[0].stall_rx) hold_requests++;
               void'(pending_ops.pop_front());
               offer = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
               end
            end
         end
      end
      req_valid <= offer;
   end

   // Receiver: check each taken beat, then pick the next ready value.
   always @(posedge clock) begin : drain_rsp
      logic take;
      take = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_rsp(rsp_data);
         rx_cycle++;
         if (hold_left != 0) begin
            hold_left--;
         end else if (holds_served != hold_requests) begin
            // Long hold-off: let the block back up and stall its input.
            holds_served++;
            hold_left = RX_HOLD_CYCLES - 1;
         end else begin
            // Rotate through always-ready, coin-flip, light stalls and a fixed pattern.
            case ((rx_cycle / 128) % 4)
               0: take = 1'b1;
               1: take = ($urandom_range(0, 1) != 0);
               2: take = ($urandom_range(0, 3) != 0);
               default: take = ((rx_cycle % 7) < 3);
            endcase
         end
      end
      rsp_ready <= take;
   end

   initial begin : run
      int  start;
      int  rand_ops;
      bit  need_hold;
      int  k;
      logic [1:0] f;

      // Directed: empty cases, extremes, duplicates, hits and misses, both dump codes.
      push_op(FUNC_DUMP,   32'sh1234_5678);
      push_op(FUNC_DELETE, 32'sh8000_0000);
      push_op(FUNC_INSERT, 32'sh0000_0000);
      push_op(FUNC_INSERT, 32'sh7fff_ffff);
      push_op(FUNC_INSERT, 32'sh8000_0000);
      push_op(FUNC_INSERT, -1);
      push_op(FUNC_INSERT, 32'sh0000_0000);
      push_op(FUNC_INSERT, 32'sh7fff_ffff);
      push_op(FUNC_INSERT, 32'sh5555_5555);
      push_op(FUNC_INSERT, 32'shaaaa_aaaa);
      push_op(FUNC_DUMP,   32'sh0000_0000);
      push_op(FUNC_DELETE, 32'sh0000_0005);
      push_op(FUNC_DELETE, 32'sh0000_0000);
      push_op(FUNC_DELETE, 32'sh8000_0000);
      push_op(FUNC_DELETE, 32'sh7fff_ffff);
      push_op(FUNC_DUMP_ALT, -1);
      push_op(FUNC_DELETE, 32'shaaaa_aaaa);
      push_op(FUNC_DELETE, 32'sh5555_5555);
      push_op(FUNC_DELETE, -1);
      push_op(FUNC_DELETE, 32'sh7fff_ffff);
      push_op(FUNC_DELETE, 32'sh0000_0000);
      push_op(FUNC_DELETE, 32'sh0000_0000);
      push_op(FUNC_DUMP_ALT, 32'sh0000_0000);
      push_drain();

      // Random: fill-to-overflow, drain-to-empty and mixed episodes.
      // Open with a fill episode so the long receiver hold-off always runs.
      rand_ops  = 0;
      need_hold = 1'b1;
      while (rand_ops < RANDOM_OPS) begin
         start = total_ops;
         case (need_hold ? 0 : $urandom_range(0, 5))
            0, 1: begin
               if (need_hold) begin
                  push_op(FUNC_DUMP, pick_value(), 1'b1);
                  need_hold = 1'b0;
               end
               while (gen_vals.size() < DEPTH) push_op(FUNC_INSERT, pick_value());
               repeat ($urandom_range(1, 3)) push_op(FUNC_INSERT, pick_value());
               push_op(FUNC_DUMP, pick_value());
            end
            2: begin
               while (gen_vals.size() != 0) begin
                  if ($urandom_range(0, 7) == 0)
                     push_op(FUNC_DELETE, $urandom);
                  else
                     push_op(FUNC_DELETE, gen_vals[$urandom_range(0, gen_vals.size() - 1)]);
               end
               push_op(FUNC_DELETE, pick_value());
               push_op($urandom_range(0, 1) ? FUNC_DUMP : FUNC_DUMP_ALT, pick_value());
            end
            default: begin
               repeat ($urandom_range(8, 30)) begin
                  k = $urandom_range(0, 9);
                  if (k < 5)       f = FUNC_INSERT;
                  else if (k < 8)  f = FUNC_DELETE;
                  else if (k == 8) f = FUNC_DUMP;
                  else             f = FUNC_DUMP_ALT;
                  push_op(f, pick_value());
               end
            end
         endcase
         rand_ops += total_ops - start;
         if ($urandom_range(0, 5) == 0) push_drain();
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every op to be taken, every beat to arrive, then a short settle.
      while (accepted_ops != total_ops) @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
